### src/hdst_pkg.sv
`default_nettype none

package hdst_pkg;

    // Default table geometry
    localparam int HDST_SLOT_COUNT    = 128;
    localparam int HDST_DURATION_BITS = 32;

    // Fibonacci hashing multiplier; the slot hash is bits 63:32 of key * HASH_MULT
    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    // Request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // One result item as it leaves the block
    typedef struct packed {
        logic        stored;
        logic [6:0]  slot_index;
        logic        first_sample;
        logic [31:0] sample_count;
        logic [63:0] sum_ticks;
        logic [31:0] least_ticks;
        logic [31:0] greatest_ticks;
        logic [31:0] drop_total;
    } t_result;

endpackage

`default_nettype wire

### src/hdst_hash.sv
`default_nettype none

module hdst_hash
    import hdst_pkg::*;
#(
    parameter int SLOT_COUNT = HDST_SLOT_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [63:0]                   i_key,
    output logic                               o_done,
    output logic [$clog2(SLOT_COUNT)-1:0]      o_slot
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam bit POW2  = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

    // Reciprocal ceil(2^(32+IDX_W) / SLOT_COUNT); bit 32 is always set
    localparam logic [63:0] RECIP =
        ((64'd1 << (32 + IDX_W)) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic [31:0] DIVISOR  = 32'(SLOT_COUNT);

    typedef enum logic [3:0] {
        H_IDLE,
        H_MUL_LL,
        H_MUL_LH,
        H_MUL_HL,
        H_ADD_HL,
        H_RECIP,
        H_QUOT,
        H_BACK,
        H_REDUCE
    } t_hstate;

    t_hstate            r_state;
    logic [63:0]        r_key;
    logic [63:0]        r_prod;
    logic [31:0]        r_acc;
    logic [31:0]        r_quo;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [32:0]        quo_sum;
    logic [32:0]        quo_wide;
    logic [31:0]        rem_full;

    // One shared 32x32 multiplier, operands picked by the step
    always_comb begin
        case (r_state)
            H_MUL_LL: begin
                mul_a = r_key[31:0];
                mul_b = HASH_MULT[31:0];
            end
            H_MUL_LH: begin
                mul_a = r_key[31:0];
                mul_b = HASH_MULT[63:32];
            end
            H_RECIP: begin
                mul_a = r_acc;
                mul_b = RECIP_LO;
            end
            H_BACK: begin
                mul_a = r_quo;
                mul_b = DIVISOR;
            end
            default: begin
                mul_a = r_key[63:32];
                mul_b = HASH_MULT[31:0];
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // Quotient by reciprocal: fold the implicit 2^32 term of RECIP back in as
    // the hash itself, then drop the extra IDX_W fraction bits
    assign quo_sum  = {1'b0, r_acc} + {1'b0, r_prod[63:32]};
    assign quo_wide = quo_sum >> IDX_W;

    // Remainder from the back-multiplied quotient
    assign rem_full = r_acc - r_prod[31:0];

    assign o_done = (r_state == H_REDUCE);
    assign o_slot = POW2 ? r_acc[IDX_W-1:0] : rem_full[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_state <= H_MUL_LL;
                    end
                end
                H_MUL_LL: begin
                    r_prod  <= mul_p;
                    r_state <= H_MUL_LH;
                end
                H_MUL_LH: begin
                    r_prod  <= mul_p;
                    r_acc   <= r_prod[63:32];
                    r_state <= H_MUL_HL;
                end
                H_MUL_HL: begin
                    r_prod  <= mul_p;
                    r_acc   <= r_acc + r_prod[31:0];
                    r_state <= H_ADD_HL;
                end
                H_ADD_HL: begin
                    r_acc <= r_acc + r_prod[31:0];
                    if (POW2) begin
                        r_state <= H_REDUCE;
                    end else begin
                        r_state <= H_RECIP;
                    end
                end
                H_RECIP: begin
                    r_prod  <= mul_p;
                    r_state <= H_QUOT;
                end
                H_QUOT: begin
                    r_quo   <= quo_wide[31:0];
                    r_state <= H_BACK;
                end
                H_BACK: begin
                    r_prod  <= mul_p;
                    r_state <= H_REDUCE;
                end
                H_REDUCE: begin
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/hashed_duration_stats_table.sv
// Per-key duration statistics kept in an open-addressed hash table.
//
// Input channel (i_valid / o_ready): one item per request. i_req_type selects
// recording a sample (i_key, i_duration) or clearing the whole table.
// Output channel (o_valid / i_ready): exactly one result item per request.
//
// A record item hashes the key on one shared 32x32 multiplier and reduces it
// to a slot (the low index bits for a power-of-two slot count, otherwise a
// reciprocal multiply and back-multiply). Each linear probe then reads the
// slot memory, then compares and writes back. After the last probe the result
// goes to a pending register and from there into the output register; a
// full table probes all SLOT_COUNT slots. A clear item sweeps the memory one
// slot per cycle. One item is worked on at a time; the next is accepted the
// cycle after the previous result is loaded into the output register. Reset
// runs the same sweep with o_ready low. A stalled receiver holds the result in
// the output register; a finished item waits in the pending register until the
// output register frees up.

`default_nettype none

module hashed_duration_stats_table
    import hdst_pkg::*;
#(
    parameter int SLOT_COUNT    = HDST_SLOT_COUNT,
    parameter int DURATION_BITS = HDST_DURATION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_duration,

    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_stored,
    output logic [6:0]       o_slot_index,
    output logic             o_first_sample,
    output logic [31:0]      o_sample_count,
    output logic [63:0]      o_sum_ticks,
    output logic [31:0]      o_least_ticks,
    output logic [31:0]      o_greatest_ticks,
    output logic [31:0]      o_drop_total
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int DB    = DURATION_BITS;

    // Slot entry layout: {key, count, sum, max, min}
    localparam int MIN_LSB = 0;
    localparam int MAX_LSB = DB;
    localparam int SUM_LSB = 2 * DB;
    localparam int CNT_LSB = 2 * DB + 64;
    localparam int KEY_LSB = 2 * DB + 96;
    localparam int ENT_W   = 2 * DB + 160;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_HASH,
        T_READ,
        T_EVAL,
        T_FINISH
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   r_probe;
    logic               r_clr_item;
    logic [63:0]        r_key;
    logic [DB-1:0]      r_dur;
    logic [31:0]        r_drop;
    logic [ENT_W-1:0]   r_rd;
    t_result            r_pend;
    t_result            r_out;
    logic               r_o_valid;

    // Slot memory, one entry per slot, registered read
    logic [ENT_W-1:0]   mem [SLOT_COUNT];

    logic               in_acc;
    logic               out_free;
    logic               h_done;
    logic [IDX_W-1:0]   h_slot;
    logic [63:0]        dur_ext;

    logic [63:0]        rd_key;
    logic [31:0]        rd_cnt;
    logic [63:0]        rd_sum;
    logic [DB-1:0]      rd_min;
    logic [DB-1:0]      rd_max;
    logic               hit;
    logic               first;
    logic [DB-1:0]      upd_min;
    logic [DB-1:0]      upd_max;
    logic [64:0]        sum_wide;
    logic [63:0]        upd_sum;
    logic [31:0]        upd_cnt;
    logic [63:0]        upd_key;
    logic [63:0]        min_ext;
    logic [63:0]        max_ext;
    logic [31:0]        addr_ext;
    logic               wr_en;
    logic [ENT_W-1:0]   wr_data;
    logic [IDX_W-1:0]   next_addr;
    logic [31:0]        drop_inc;
    t_result            drop_res;

    assign o_ready  = (r_state == T_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign dur_ext  = 64'(i_duration);

    hdst_hash #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && (i_req_type == REQ_RECORD)),
        .i_key   (i_key),
        .o_done  (h_done),
        .o_slot  (h_slot)
    );

    // Split the entry read back from memory
    assign rd_key = r_rd[KEY_LSB +: 64];
    assign rd_cnt = r_rd[CNT_LSB +: 32];
    assign rd_sum = r_rd[SUM_LSB +: 64];
    assign rd_min = r_rd[MIN_LSB +: DB];
    assign rd_max = r_rd[MAX_LSB +: DB];

    // Empty slot or same key takes the sample; a slot with no samples is claimed
    assign hit   = (rd_key == 64'd0) || (rd_key == r_key);
    assign first = (rd_cnt == 32'd0);

    always_comb begin
        if (first) begin
            upd_min = r_dur;
            upd_max = r_dur;
        end else begin
            upd_min = (r_dur < rd_min) ? r_dur : rd_min;
            upd_max = (r_dur > rd_max) ? r_dur : rd_max;
        end
    end

    // Saturating total and count
    assign sum_wide = {1'b0, rd_sum} + {1'b0, 64'(r_dur)};
    assign upd_sum  = sum_wide[64] ? '1 : sum_wide[63:0];
    assign upd_cnt  = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;
    assign upd_key  = first ? r_key : rd_key;
    assign drop_inc = (r_drop == 32'hFFFF_FFFF) ? r_drop : r_drop + 32'd1;

    // A dropped item reports only the drop counter
    always_comb begin
        drop_res            = '0;
        drop_res.drop_total = drop_inc;
    end

    assign min_ext  = 64'(upd_min);
    assign max_ext  = 64'(upd_max);
    assign addr_ext = 32'(r_addr);

    assign next_addr = (r_addr == LAST_SLOT) ? '0 : r_addr + IDX_W'(1);

    assign wr_en   = (r_state == T_CLEAR) || ((r_state == T_EVAL) && hit);
    assign wr_data = (r_state == T_CLEAR) ? '0
                   : {upd_key, upd_cnt, upd_sum, upd_max, upd_min};

    // Memory port: write on sweep or update, read when a probe starts
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (r_state == T_READ) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLEAR;
            r_addr     <= '0;
            r_clr_item <= 1'b0;
            r_drop     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // Load a finished result, or drop the output once taken
            if ((r_state == T_FINISH) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                T_CLEAR: begin
                    // Sweep zeros through the table
                    r_addr <= next_addr;
                    if (r_addr == LAST_SLOT) begin
                        if (r_clr_item) begin
                            r_pend  <= '0;
                            r_state <= T_FINISH;
                        end else begin
                            r_state <= T_IDLE;
                        end
                    end
                end
                T_IDLE: begin
                    if (in_acc) begin
                        if (i_req_type == REQ_CLEAR) begin
                            r_clr_item <= 1'b1;
                            r_drop     <= '0;
                            r_addr     <= '0;
                            r_state    <= T_CLEAR;
                        end else begin
                            r_key   <= i_key;
                            r_dur   <= dur_ext[DB-1:0];
                            r_state <= T_HASH;
                        end
                    end
                end
                T_HASH: begin
                    if (h_done) begin
                        r_addr  <= h_slot;
                        r_probe <= '0;
                        r_state <= T_READ;
                    end
                end
                T_READ: begin
                    r_state <= T_EVAL;
                end
                T_EVAL: begin
                    if (hit) begin
                        r_pend.stored         <= 1'b1;
                        r_pend.slot_index     <= addr_ext[6:0];
                        r_pend.first_sample   <= first;
                        r_pend.sample_count   <= upd_cnt;
                        r_pend.sum_ticks      <= upd_sum;
                        r_pend.least_ticks    <= min_ext[31:0];
                        r_pend.greatest_ticks <= max_ext[31:0];
                        r_pend.drop_total     <= r_drop;
                        r_state               <= T_FINISH;
                    end else if (r_probe == LAST_SLOT) begin
                        // Every slot holds a foreign key: drop the sample
                        r_drop  <= drop_inc;
                        r_pend  <= drop_res;
                        r_state <= T_FINISH;
                    end else begin
                        r_probe <= r_probe + IDX_W'(1);
                        r_addr  <= next_addr;
                        r_state <= T_READ;
                    end
                end
                T_FINISH: begin
                    // Hold the result until the output register frees up
                    if (out_free) begin
                        r_out      <= r_pend;
                        r_clr_item <= 1'b0;
                        r_state    <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_stored         = r_out.stored;
    assign o_slot_index     = r_out.slot_index;
    assign o_first_sample   = r_out.first_sample;
    assign o_sample_count   = r_out.sample_count;
    assign o_sum_ticks      = r_out.sum_ticks;
    assign o_least_ticks    = r_out.least_ticks;
    assign o_greatest_ticks = r_out.greatest_ticks;
    assign o_drop_total     = r_out.drop_total;

    // The hash unit only reports while the sequencer waits for it
    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_done |-> (r_state == T_HASH))
        else $error("hash result outside hash wait");

    // A slot that takes a sample always ends up with a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == T_EVAL) && hit) |-> (upd_cnt != 32'd0))
        else $error("updated slot count is zero");

    // The drop counter only falls on a clear item
    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_acc && (i_req_type == REQ_CLEAR)))
            |-> (r_drop >= $past(r_drop)))
        else $error("drop counter decreased without clear");

    // A new item is never taken while a finished result is still pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FINISH) |-> !o_ready)
        else $error("item accepted while result pending");

endmodule

`default_nettype wire
